// ===== rtl/core/assert_macros.svh =====
// Assertion macros shared by the RTL of the deque block.
// No dependencies; the bodies are empty when SYNTH is defined.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTH
// The expression holds at every clock edge outside reset.
`define ASSERT_ALWAYS(lbl, clk, rstn, expr, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (expr)) else $error(msg);
// The antecedent in one cycle implies the consequent in the next.
`define ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) else $error(msg);
`else
`define ASSERT_ALWAYS(lbl, clk, rstn, expr, msg)
`define ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg)
`endif
`endif

// ===== rtl/core/deq_pkg.sv =====
// Package of the double-ended queue: payload types, command codes, state codes.
// No dependencies; used by the controller, the datapath and the top level.
package deq_pkg;

  localparam int DEPTH_DEF = 1024;
  localparam int DATA_W    = 32;
  localparam int COUNT_W   = 11;

  typedef enum logic [2:0] {
    CMD_PUSH_FRONT = 3'd0,
    CMD_PUSH_BACK  = 3'd1,
    CMD_POP_FRONT  = 3'd2,
    CMD_POP_BACK   = 3'd3,
    CMD_PEEK       = 3'd4
  } deq_cmd_t;

  typedef enum logic [1:0] {
    ST_IDLE = 2'd0,
    ST_EXEC = 2'd1,
    ST_LOOK = 2'd2,
    ST_DONE = 2'd3
  } deq_state_t;

  typedef struct packed {
    logic [2:0]               command;
    logic signed [DATA_W-1:0] value;
  } deq_in_t;

  typedef struct packed {
    logic signed [DATA_W-1:0] popped_value;
    logic                     error;
    logic [COUNT_W-1:0]       entry_count;
    logic                     is_empty;
    logic signed [DATA_W-1:0] front_value;
    logic signed [DATA_W-1:0] back_value;
  } deq_out_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic capture;
    logic exec;
    logic look;
    logic load;
  } deq_ctl_t;

endpackage

// ===== rtl/core/deq_ram.sv =====
// Generic RAM: one write port, two read ports with registered read data.
// No dependencies.
module deq_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr_a,
  output logic [WIDTH-1:0]         rdata_a,
  input  logic [$clog2(DEPTH)-1:0] raddr_b,
  output logic [WIDTH-1:0]         rdata_b
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port and registered read ports.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_a <= mem[raddr_a];
    rdata_b <= mem[raddr_b];
  end

endmodule

// ===== rtl/core/deq_ctrl.sv =====
// Controller of the deque: sequences each item and owns the result valid flag.
// Depends on deq_pkg.
module deq_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  output logic              out_valid,
  input  logic              out_stall,
  output deq_pkg::deq_ctl_t ctl
);

  deq_pkg::deq_state_t state_r, state_nxt;
  logic                out_valid_r, out_valid_nxt;

  // Next state.
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      deq_pkg::ST_IDLE: begin
        if (in_valid) begin
          state_nxt = deq_pkg::ST_EXEC;
        end
      end
      deq_pkg::ST_EXEC: state_nxt = deq_pkg::ST_LOOK;
      deq_pkg::ST_LOOK: state_nxt = deq_pkg::ST_DONE;
      deq_pkg::ST_DONE: begin
        if (!out_valid_r || !out_stall) begin
          state_nxt = deq_pkg::ST_IDLE;
        end
      end
      default: state_nxt = deq_pkg::ST_IDLE;
    endcase
  end

  // Outputs of the state machine.
  always_comb begin
    in_stall    = 1'b1;
    ctl.capture = 1'b0;
    ctl.exec    = 1'b0;
    ctl.look    = 1'b0;
    ctl.load    = 1'b0;
    unique case (state_r)
      deq_pkg::ST_IDLE: begin
        in_stall    = 1'b0;
        ctl.capture = in_valid;
      end
      deq_pkg::ST_EXEC: ctl.exec = 1'b1;
      deq_pkg::ST_LOOK: ctl.look = 1'b1;
      deq_pkg::ST_DONE: ctl.load = !out_valid_r || !out_stall;
      default: in_stall = 1'b1;
    endcase
  end

  // The result stays valid until its transfer, unless a new one replaces it.
  always_comb begin
    if (ctl.load) begin
      out_valid_nxt = 1'b1;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= deq_pkg::ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_valid = out_valid_r;

endmodule

// ===== rtl/core/deq_datapath.sv =====
// Datapath of the deque: pointers, count, ring store and the result register.
// Depends on deq_pkg, deq_ram and assert_macros.svh.
`include "assert_macros.svh"

module deq_datapath #(
  parameter int DEPTH = deq_pkg::DEPTH_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  deq_pkg::deq_ctl_t ctl,
  input  deq_pkg::deq_in_t  in_data,
  output deq_pkg::deq_out_t out_data
);

  localparam int AW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);

  logic [AW-1:0]             front_r, front_nxt;
  logic [AW-1:0]             back_r, back_nxt;
  logic [CW-1:0]             count_r, count_nxt;
  logic [2:0]                cmd_r;
  logic [deq_pkg::DATA_W-1:0] val_r;
  logic                      err_r, err_nxt;
  logic                      pop_ok_r, pop_ok_nxt;
  logic [deq_pkg::DATA_W-1:0] popped_r;
  deq_pkg::deq_out_t         out_r;

  logic                      we;
  logic [AW-1:0]             waddr;
  logic [AW-1:0]             pop_addr;
  logic [AW-1:0]             raddr_a;
  logic [AW-1:0]             raddr_b;
  logic [deq_pkg::DATA_W-1:0] rdata_a;
  logic [deq_pkg::DATA_W-1:0] rdata_b;
  logic                      full;
  logic                      empty;

  function automatic logic [AW-1:0] ring_next(input logic [AW-1:0] p);
    ring_next = (p == AW'(DEPTH - 1)) ? '0 : p + 1'b1;
  endfunction

  function automatic logic [AW-1:0] ring_prev(input logic [AW-1:0] p);
    ring_prev = (p == '0) ? AW'(DEPTH - 1) : p - 1'b1;
  endfunction

  assign full  = (count_r == CW'(DEPTH));
  assign empty = (count_r == '0);

  // Command decode: pointer moves, count update, store write and pop address.
  always_comb begin
    front_nxt  = front_r;
    back_nxt   = back_r;
    count_nxt  = count_r;
    err_nxt    = 1'b0;
    pop_ok_nxt = 1'b0;
    we         = 1'b0;
    waddr      = back_r;
    pop_addr   = front_r;
    unique case (cmd_r)
      deq_pkg::CMD_PUSH_FRONT: begin
        if (full) begin
          err_nxt = 1'b1;
        end else begin
          front_nxt = ring_prev(front_r);
          waddr     = ring_prev(front_r);
          we        = ctl.exec;
          count_nxt = count_r + 1'b1;
        end
      end
      deq_pkg::CMD_PUSH_BACK: begin
        if (full) begin
          err_nxt = 1'b1;
        end else begin
          waddr     = back_r;
          we        = ctl.exec;
          back_nxt  = ring_next(back_r);
          count_nxt = count_r + 1'b1;
        end
      end
      deq_pkg::CMD_POP_FRONT: begin
        if (empty) begin
          err_nxt = 1'b1;
        end else begin
          pop_addr   = front_r;
          front_nxt  = ring_next(front_r);
          count_nxt  = count_r - 1'b1;
          pop_ok_nxt = 1'b1;
        end
      end
      deq_pkg::CMD_POP_BACK: begin
        if (empty) begin
          err_nxt = 1'b1;
        end else begin
          pop_addr   = ring_prev(back_r);
          back_nxt   = ring_prev(back_r);
          count_nxt  = count_r - 1'b1;
          pop_ok_nxt = 1'b1;
        end
      end
      default: begin
        // Peek and the unused codes leave everything as it is.
        err_nxt = 1'b0;
      end
    endcase
  end

  // Port A reads the popped slot while executing and the front slot after.
  assign raddr_a = ctl.exec ? pop_addr : front_r;
  assign raddr_b = ring_prev(back_r);

  deq_ram #(
    .WIDTH (deq_pkg::DATA_W),
    .DEPTH (DEPTH)
  ) u_ram (
    .clk     (clk),
    .we      (we),
    .waddr   (waddr),
    .wdata   (val_r),
    .raddr_a (raddr_a),
    .rdata_a (rdata_a),
    .raddr_b (raddr_b),
    .rdata_b (rdata_b)
  );

  // Queue state registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      front_r <= '0;
      back_r  <= '0;
      count_r <= '0;
    end else if (ctl.exec) begin
      front_r <= front_nxt;
      back_r  <= back_nxt;
      count_r <= count_nxt;
    end
  end

  // Item capture, per-item flags and the popped value.
  always_ff @(posedge clk) begin
    if (ctl.capture) begin
      cmd_r <= in_data.command;
      val_r <= in_data.value;
    end
    if (ctl.exec) begin
      err_r    <= err_nxt;
      pop_ok_r <= pop_ok_nxt;
    end
    if (ctl.look) begin
      popped_r <= pop_ok_r ? rdata_a : '0;
    end
  end

  // Result register; front and back slots are read out by now.
  always_ff @(posedge clk) begin
    if (ctl.load) begin
      out_r.popped_value <= popped_r;
      out_r.error        <= err_r;
      out_r.entry_count  <= deq_pkg::COUNT_W'(count_r);
      out_r.is_empty     <= empty;
      out_r.front_value  <= empty ? '0 : rdata_a;
      out_r.back_value   <= empty ? '0 : rdata_b;
    end
  end

  assign out_data = out_r;

  `ASSERT_ALWAYS(a_count_bound, clk, rst_n, count_r <= CW'(DEPTH), "count beyond depth")
  `ASSERT_ALWAYS(a_empty_ptrs, clk, rst_n, !empty || (front_r == back_r), "empty ring pointers differ")
  `ASSERT_ALWAYS(a_full_ptrs, clk, rst_n, !full || (front_r == back_r), "full ring pointers differ")
  `ASSERT_NEXT(a_count_hold, clk, rst_n, !ctl.exec, $stable(count_r), "count moved outside execute")

endmodule

// ===== rtl/core/double_ended_queue.sv =====
// Top level of the double-ended queue: controller plus datapath.
// Depends on deq_pkg, deq_ctrl and deq_datapath.
//
//  Channel   Direction  Handshake            Payload
//  in_*      input      in_valid / in_stall  deq_in_t  (command, value)
//  out_*     output     out_valid / out_stall deq_out_t (popped, error, count, empty,
//                                                      front, back)
//
// An item passes through the controller states in order: accept, execute (store write or
// pop read), look-up of the front and back slots, load; the look-up step exists because the
// two read ports of the ring store are registered. The next input can be accepted in the
// cycle after the load, so a new item is taken only once the earlier one has been loaded.
// Reset (rst_n low, synchronous) empties the queue; the store itself is not cleared.
// A result waiting under out_stall does not block the next item, which only waits
// in its load step while the earlier result is still held.
module double_ended_queue #(
  parameter int DEPTH = deq_pkg::DEPTH_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  deq_pkg::deq_in_t  in_data,
  output logic              out_valid,
  input  logic              out_stall,
  output deq_pkg::deq_out_t out_data
);

  deq_pkg::deq_ctl_t ctl;

  deq_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .ctl       (ctl)
  );

  deq_datapath #(
    .DEPTH (DEPTH)
  ) u_datapath (
    .clk      (clk),
    .rst_n    (rst_n),
    .ctl      (ctl),
    .in_data  (in_data),
    .out_data (out_data)
  );

endmodule
